[hw/rtl/marquee_scroll_controller_defines.svh]
// ----------------------------------------------------------------------------
// Marquee scroll controller assertion macros
// Shared property shapes for the port checker.
// ----------------------------------------------------------------------------
`ifndef MARQUEE_SCROLL_CONTROLLER_DEFINES_SVH
`define MARQUEE_SCROLL_CONTROLLER_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define MSC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("marquee scroll controller: implication failed");

// Next-cycle implication, disabled in reset
`define MSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("marquee scroll controller: next-cycle check failed");

`endif

[hw/rtl/msc_pkg.sv]
// ----------------------------------------------------------------------------
// Marquee scroll controller package
// Command, phase and register codes and the fixed scroll constants.
// ----------------------------------------------------------------------------
package msc_pkg;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_LOAD  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic REG_DISPLAY_WIDTH = 1'b0;
    localparam logic REG_SIDE_PADDING  = 1'b1;

    localparam logic [2:0] PH_CODE_EMPTY  = 3'd0;
    localparam logic [2:0] PH_CODE_NEW    = 3'd1;
    localparam logic [2:0] PH_CODE_FIXED  = 3'd2;
    localparam logic [2:0] PH_CODE_WAITL  = 3'd3;
    localparam logic [2:0] PH_CODE_SCROLL = 3'd4;
    localparam logic [2:0] PH_CODE_WAITR  = 3'd5;
    localparam logic [2:0] PH_CODE_RETURN = 3'd6;

    localparam logic [9:0] DISPLAY_WIDTH_RESET = 10'd240;
    localparam logic [7:0] SIDE_PADDING_RESET  = 8'd10;

    localparam logic [6:0]         WAIT_FIRST  = 7'd30;
    localparam logic [6:0]         WAIT_END    = 7'd60;
    localparam logic signed [13:0] SCROLL_STEP = 14'sd2;
    localparam logic [10:0]        RETURN_MIN  = 11'd4;

    typedef enum logic [6:0] {
        PH_EMPTY  = 7'b0000001,
        PH_NEW    = 7'b0000010,
        PH_FIXED  = 7'b0000100,
        PH_WAITL  = 7'b0001000,
        PH_SCROLL = 7'b0010000,
        PH_WAITR  = 7'b0100000,
        PH_RETURN = 7'b1000000
    } t_phase;

    function automatic logic [2:0] phase_code(input t_phase p);
        logic [2:0] code;
        unique case (p)
            PH_NEW:    code = PH_CODE_NEW;
            PH_FIXED:  code = PH_CODE_FIXED;
            PH_WAITL:  code = PH_CODE_WAITL;
            PH_SCROLL: code = PH_CODE_SCROLL;
            PH_WAITR:  code = PH_CODE_WAITR;
            PH_RETURN: code = PH_CODE_RETURN;
            default:   code = PH_CODE_EMPTY;
        endcase
        return code;
    endfunction

endpackage

[hw/rtl/marquee_scroll_controller.sv]
// ----------------------------------------------------------------------------
// Marquee scroll controller
// Sequences the horizontal position of one scrolling text label per tick.
// ----------------------------------------------------------------------------
// Input stream (s_*): one command per transfer, tuser carries the command
// (tick, load, clear) and tdata the text width used on load.
// Output stream (m_*): exactly one result per input transfer, in order;
// tdata carries the signed x position, tuser the redraw and blank flags
// and the phase after the command.
// Configuration: APB port, display width at 0x0, side padding at 0x4; the user
// must write them only while idle; the block does not enforce it. pready is tied high.
// Path: the input transfer is held in the input register, then one
// combinational update writes the result register and state; the result
// transfer then waits for m_tready.
// Throughput: one item per cycle while m_tready is high; the state update is
// a single pass of a few adds and compares, so only a stall lowers the rate.
// Stall: while m_tready is low the result holds, one further item waits in
// the input register, then s_tready drops.
// Reset (synchronous, active low): empties both stages, restores register
// defaults and clears all label state to the empty phase.
// ----------------------------------------------------------------------------
module marquee_scroll_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] lbl_width, [15:12] zero
    input  logic [1:0]  s_tuser,   // [1:0] cmd

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [13:0] x_position, [15:14] zero
    output logic [4:0]  m_tuser,   // [0] redraw, [1] blank_last, [4:2] phase

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic               w_reg_sel;
    logic [9:0]         r_display_width;
    logic [7:0]         r_side_padding;

    logic               r_in_vld;
    logic [1:0]         r_in_cmd;
    logic [11:0]        r_in_tw;

    logic               r_out_vld;
    logic signed [13:0] r_out_x;
    logic               r_out_redraw;
    logic               r_out_blank;
    logic [2:0]         r_out_phase;

    msc_pkg::t_phase    r_phase, n_phase;
    logic [11:0]        r_lw, n_lw;
    logic signed [13:0] r_pos, n_pos;
    logic signed [13:0] r_home, n_home;
    logic signed [13:0] r_far, n_far;
    logic [6:0]         r_wait, n_wait;
    logic               r_drawn, n_drawn;
    logic               n_redraw;
    logic               n_blank;

    logic               w_advance;
    logic signed [13:0] w_diff;
    logic signed [13:0] w_centre;
    logic signed [13:0] w_pad;
    logic signed [13:0] w_home;
    logic signed [13:0] w_span;
    logic               w_scroll;
    logic signed [13:0] w_far;
    logic signed [13:0] w_dec;
    logic signed [13:0] w_dist;
    logic [13:0]        w_abs;
    logic signed [13:0] w_step;
    logic signed [13:0] w_inc;

    // ------------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------------
    assign w_reg_sel = paddr[2];
    assign pready    = 1'b1;
    assign prdata    = (w_reg_sel == msc_pkg::REG_SIDE_PADDING) ? {24'd0, r_side_padding}
                                                                : {22'd0, r_display_width};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_display_width <= msc_pkg::DISPLAY_WIDTH_RESET;
            r_side_padding  <= msc_pkg::SIDE_PADDING_RESET;
        end else if (psel && penable && pwrite && pready) begin
            if (w_reg_sel == msc_pkg::REG_SIDE_PADDING) begin
                r_side_padding <= pwdata[7:0];
            end else begin
                r_display_width <= pwdata[9:0];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------------
    assign w_advance = r_in_vld && (!r_out_vld || m_tready);
    assign s_tready  = !r_in_vld || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            r_in_vld <= 1'b1;
        end else if (w_advance) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            r_in_cmd <= s_tuser;
            r_in_tw  <= s_tdata[11:0];
        end
    end

    // ------------------------------------------------------------------------
    // Position arithmetic
    // ------------------------------------------------------------------------
    assign w_diff   = $signed({4'd0, r_display_width}) - $signed({2'd0, r_lw});
    assign w_centre = (w_diff >>> 1) + $signed({13'd0, w_diff[13] & w_diff[0]});
    assign w_pad    = $signed({6'd0, r_side_padding});
    assign w_home   = (w_centre > w_pad) ? w_centre : w_pad;
    assign w_span   = $signed({4'd0, r_display_width})
                    - $signed({5'd0, r_side_padding, 1'b0});
    assign w_scroll = $signed({2'd0, r_lw}) > w_span;
    assign w_far    = w_diff - w_pad;

    assign w_dec    = r_pos - msc_pkg::SCROLL_STEP;
    assign w_dist   = r_pos - r_home;
    assign w_abs    = w_dist[13] ? 14'(-w_dist) : 14'(w_dist);
    assign w_step   = (w_abs[13:3] < msc_pkg::RETURN_MIN) ? $signed({3'd0, msc_pkg::RETURN_MIN})
                                                          : $signed({3'd0, w_abs[13:3]});
    assign w_inc    = r_pos + w_step;

    // ------------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------------
    always_comb begin
        n_phase  = r_phase;
        n_lw     = r_lw;
        n_pos    = r_pos;
        n_home   = r_home;
        n_far    = r_far;
        n_wait   = r_wait;
        n_drawn  = r_drawn;
        n_redraw = 1'b0;
        n_blank  = 1'b0;
        unique case (r_in_cmd)
            msc_pkg::CMD_TICK: begin
                unique case (r_phase)
                    msc_pkg::PH_NEW: begin
                        n_home   = w_home;
                        n_pos    = w_home;
                        n_redraw = 1'b1;
                        if (w_scroll) begin
                            n_far   = w_far;
                            n_phase = msc_pkg::PH_WAITL;
                            n_wait  = msc_pkg::WAIT_FIRST;
                        end else begin
                            n_phase = msc_pkg::PH_FIXED;
                        end
                    end
                    msc_pkg::PH_WAITL, msc_pkg::PH_WAITR: begin
                        if (r_wait != 7'd0) begin
                            n_wait = r_wait - 7'd1;
                        end else if (r_phase == msc_pkg::PH_WAITL) begin
                            n_phase = msc_pkg::PH_SCROLL;
                        end else begin
                            n_phase = msc_pkg::PH_RETURN;
                        end
                    end
                    msc_pkg::PH_SCROLL: begin
                        n_redraw = 1'b1;
                        if (w_dec <= r_far) begin
                            n_pos   = r_far;
                            n_phase = msc_pkg::PH_WAITR;
                            n_wait  = msc_pkg::WAIT_END;
                        end else begin
                            n_pos = w_dec;
                        end
                    end
                    msc_pkg::PH_RETURN: begin
                        n_redraw = 1'b1;
                        if (w_inc >= r_home) begin
                            n_pos   = r_home;
                            n_phase = msc_pkg::PH_WAITL;
                            n_wait  = msc_pkg::WAIT_END;
                        end else begin
                            n_pos = w_inc;
                        end
                    end
                    default: begin
                    end
                endcase
                if (n_redraw) begin
                    n_drawn = 1'b1;
                end
            end
            msc_pkg::CMD_LOAD: begin
                n_lw    = r_in_tw;
                n_phase = msc_pkg::PH_NEW;
                n_wait  = 7'd0;
            end
            msc_pkg::CMD_CLEAR: begin
                n_blank = r_drawn;
                n_drawn = 1'b0;
                n_phase = msc_pkg::PH_EMPTY;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= msc_pkg::PH_EMPTY;
            r_lw    <= 12'd0;
            r_pos   <= 14'sd0;
            r_home  <= 14'sd0;
            r_far   <= 14'sd0;
            r_wait  <= 7'd0;
            r_drawn <= 1'b0;
        end else if (w_advance) begin
            r_phase <= n_phase;
            r_lw    <= n_lw;
            r_pos   <= n_pos;
            r_home  <= n_home;
            r_far   <= n_far;
            r_wait  <= n_wait;
            r_drawn <= n_drawn;
        end
    end

    // ------------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_advance) begin
            r_out_vld <= 1'b1;
        end else if (m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_x      <= n_pos;
            r_out_redraw <= n_redraw;
            r_out_blank  <= n_blank;
            r_out_phase  <= msc_pkg::phase_code(n_phase);
        end
    end

    assign m_tvalid = r_out_vld;
    assign m_tdata  = {2'b00, r_out_x};
    assign m_tuser  = {r_out_phase, r_out_blank, r_out_redraw};

endmodule

[hw/rtl/msc_checker.sv]
// ----------------------------------------------------------------------------
// Marquee scroll controller port checker
// Watches the output stream for result consistency and stall behaviour.
// ----------------------------------------------------------------------------
`include "marquee_scroll_controller_defines.svh"

module msc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [4:0]  m_tuser
);

    `MSC_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    `MSC_ASSERT_IMPLY(a_flags_excl, i_clk, i_rst_n, m_tvalid, !(m_tuser[0] && m_tuser[1]))
    `MSC_ASSERT_IMPLY(a_blank_empty, i_clk, i_rst_n, m_tvalid && m_tuser[1], m_tuser[4:2] == msc_pkg::PH_CODE_EMPTY)
    `MSC_ASSERT_IMPLY(a_redraw_phase, i_clk, i_rst_n, m_tvalid && m_tuser[0], m_tuser[4:2] != msc_pkg::PH_CODE_EMPTY && m_tuser[4:2] != msc_pkg::PH_CODE_NEW)

endmodule

bind marquee_scroll_controller msc_checker u_msc_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[bench/marquee_scroll_controller_test.sv]
// ----------------------------------------------------------------------------
// Marquee scroll controller testbench
// Drives tick, load, clear and unused commands into the input stream, with
// bursty input and a stalling receiver, and rewrites display width and side
// padding between phases. A scoreboard class tracks the label state
// (phase, home and far positions, hold countdown, drawn flag) and checks
// every result transfer, field by field and in order.
// ----------------------------------------------------------------------------
module marquee_scroll_controller_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int        SCROLL_PX    = 2;
    localparam int        RETURN_DIV   = 8;
    localparam int        RETURN_FLOOR = 4;
    localparam logic [6:0] HOLD_FIRST  = 7'd30;
    localparam logic [6:0] HOLD_END    = 7'd60;

    typedef struct {
        logic [13:0] x;
        logic        redraw;
        logic        blank;
        logic [2:0]  phase;
    } t_scroll_frame;

    class scroll_scoreboard;
        logic [9:0]    disp_w;
        logic [7:0]    pad;
        logic [2:0]    phase;
        logic [11:0]   label_w;
        int            pos;
        int            home;
        int            far_end;
        logic [6:0]    hold_cnt;
        bit            on_screen;
        t_scroll_frame due_frames[$];
        int            errors;

        function new();
            disp_w    = msc_pkg::DISPLAY_WIDTH_RESET;
            pad       = msc_pkg::SIDE_PADDING_RESET;
            phase     = msc_pkg::PH_CODE_EMPTY;
            label_w   = '0;
            pos       = 0;
            home      = 0;
            far_end   = 0;
            hold_cnt  = '0;
            on_screen = 0;
            errors    = 0;
        endfunction

        function void write_reg(logic idx, logic [31:0] val);
            if (idx == msc_pkg::REG_DISPLAY_WIDTH) begin
                disp_w = val[9:0];
            end else begin
                pad = val[7:0];
            end
        endfunction

        function int outstanding();
            return due_frames.size();
        endfunction

        function void note_command(logic [1:0] cmd, logic [11:0] tw);
            int            dw;
            int            p;
            int            w;
            int            centre;
            int            gap;
            int            step;
            logic          draw;
            logic          blank;
            t_scroll_frame f;
            dw    = disp_w;
            p     = pad;
            w     = label_w;
            draw  = 1'b0;
            blank = 1'b0;
            case (cmd)
                msc_pkg::CMD_TICK: begin
                    case (phase)
                        msc_pkg::PH_CODE_NEW: begin
                            centre = (dw - w) / 2;
                            home   = (centre > p) ? centre : p;
                            pos    = home;
                            if (w > dw - 2 * p) begin
                                far_end  = dw - w - p;
                                phase    = msc_pkg::PH_CODE_WAITL;
                                hold_cnt = HOLD_FIRST;
                            end else begin
                                phase = msc_pkg::PH_CODE_FIXED;
                            end
                            draw = 1'b1;
                        end
                        msc_pkg::PH_CODE_WAITL, msc_pkg::PH_CODE_WAITR: begin
                            if (hold_cnt != 0) begin
                                hold_cnt = hold_cnt - 7'd1;
                            end else begin
                                phase = (phase == msc_pkg::PH_CODE_WAITL)
                                      ? msc_pkg::PH_CODE_SCROLL
                                      : msc_pkg::PH_CODE_RETURN;
                            end
                        end
                        msc_pkg::PH_CODE_SCROLL: begin
                            pos  = pos - SCROLL_PX;
                            draw = 1'b1;
                            if (pos <= far_end) begin
                                pos      = far_end;
                                phase    = msc_pkg::PH_CODE_WAITR;
                                hold_cnt = HOLD_END;
                            end
                        end
                        msc_pkg::PH_CODE_RETURN: begin
                            gap = pos - home;
                            if (gap < 0) gap = -gap;
                            step = gap / RETURN_DIV;
                            if (step < RETURN_FLOOR) step = RETURN_FLOOR;
                            pos  = pos + step;
                            draw = 1'b1;
                            if (pos >= home) begin
                                pos      = home;
                                phase    = msc_pkg::PH_CODE_WAITL;
                                hold_cnt = HOLD_END;
                            end
                        end
                        default: ;
                    endcase
                    if (draw) on_screen = 1;
                end
                msc_pkg::CMD_LOAD: begin
                    label_w  = tw;
                    phase    = msc_pkg::PH_CODE_NEW;
                    hold_cnt = '0;
                end
                msc_pkg::CMD_CLEAR: begin
                    blank     = on_screen;
                    on_screen = 0;
                    phase     = msc_pkg::PH_CODE_EMPTY;
                end
                default: ;
            endcase
            f.x      = pos[13:0];
            f.redraw = draw;
            f.blank  = blank;
            f.phase  = phase;
            due_frames.push_back(f);
        endfunction

        function void check_frame(logic [15:0] tdata, logic [4:0] tuser);
            t_scroll_frame f;
            logic [15:0]   exp_data;
            logic [4:0]    exp_user;
            if (due_frames.size() == 0) begin
                errors++;
                if (errors <= 30)
                    $display("%0t ns: unexpected result, expected none, actual tdata=%h tuser=%b",
                             $time, tdata, tuser);
                return;
            end
            f        = due_frames.pop_front();
            exp_data = {2'b00, f.x};
            exp_user = {f.phase, f.blank, f.redraw};
            if (tdata !== exp_data || tuser !== exp_user) begin
                errors++;
                if (errors <= 30)
                    $display({"%0t ns: result mismatch, expected x=%0d redraw=%0b blank=%0b ",
                              "phase=%0d (tdata=%h), actual x=%0d redraw=%0b blank=%0b ",
                              "phase=%0d (tdata=%h)"},
                             $time, $signed(f.x), f.redraw, f.blank, f.phase, exp_data,
                             $signed(tdata[13:0]), tuser[0], tuser[1], tuser[4:2], tdata);
            end
        endfunction
    endclass

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = msc_pkg::CMD_TICK;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [4:0]  m_tuser;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    scroll_scoreboard sb = new();
    int               taken_count = 0;
    int               burst_left  = 0;
    logic [15:0]      ready_pattern = 16'hFFFF;
    int               pattern_left  = 0;
    int               pattern_pos   = 0;

    marquee_scroll_controller DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_tvalid && s_tready) begin
                sb.note_command(s_tuser, s_tdata[11:0]);
                taken_count++;
            end
            if (m_tvalid && m_tready) sb.check_frame(m_tdata, m_tuser);
        end
    end

    // Receiver: replay a 16-bit ready pattern, reroll it now and then
    always @(negedge i_clk) begin
        if (pattern_left == 0) begin
            case ($urandom_range(0, 3))
                0, 1:    ready_pattern = 16'hFFFF;
                2:       ready_pattern = 16'($urandom) | 16'h0001;
                default: ready_pattern = 16'h0101;
            endcase
            pattern_left = $urandom_range(16, 160);
        end
        m_tready <= ready_pattern[pattern_pos];
        pattern_pos  = (pattern_pos + 1) % 16;
        pattern_left--;
    end

    task automatic send_cmd(input logic [1:0] cmd, input logic [11:0] tw);
        int n;
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 8);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'b0000, tw};
        n = taken_count;
        do @(negedge i_clk); while (taken_count == n);
        burst_left--;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.outstanding() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic apb_write(input logic idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_reg(idx, val);
        @(negedge i_clk);
    endtask

    task automatic configure(input logic [31:0] width_val, input logic [31:0] pad_val);
        wait_idle();
        apb_write(msc_pkg::REG_DISPLAY_WIDTH, width_val);
        apb_write(msc_pkg::REG_SIDE_PADDING, pad_val);
    endtask

    // Load a label, then tick it through its scroll cycle with a little noise
    task automatic run_label(input int budget);
        int thr;
        int w;
        int ticks;
        int pick;
        int k;
        thr  = int'(sb.disp_w) - 2 * int'(sb.pad);
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            w = thr + int'($urandom_range(1, 48));
        end else if (pick < 78) begin
            w = (thr >= 0) ? int'($urandom_range(0, thr)) : int'($urandom_range(0, 4095));
        end else if (pick < 93) begin
            w = $urandom_range(0, 4095);
        end else begin
            w = $urandom_range(0, 1) ? 4095 : 0;
        end
        if (w < 0) w = 0;
        if (w > 4095) w = 4095;
        send_cmd(msc_pkg::CMD_LOAD, w[11:0]);
        ticks = (budget >= 200 || $urandom_range(0, 5) == 0) ? $urandom_range(200, 320)
                                                             : $urandom_range(1, 150);
        if (ticks > budget - 1) ticks = budget - 1;
        if (ticks < 1) ticks = 1;
        repeat (ticks) begin
            k = $urandom_range(0, 199);
            if (k == 0) begin
                send_cmd(msc_pkg::CMD_CLEAR, 12'($urandom));
            end else if (k == 1) begin
                send_cmd(CMD_UNUSED, 12'($urandom));
            end else if (k == 2) begin
                send_cmd(msc_pkg::CMD_LOAD, 12'($urandom));
            end else begin
                send_cmd(msc_pkg::CMD_TICK, 12'($urandom));
            end
        end
        if ($urandom_range(0, 2) == 0) send_cmd(msc_pkg::CMD_CLEAR, 12'($urandom));
    endtask

    initial begin
        int start;
        int target;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_cmd(CMD_UNUSED, 12'hFFF);
        send_cmd(msc_pkg::CMD_TICK, 12'h000);
        send_cmd(msc_pkg::CMD_CLEAR, 12'h000);
        send_cmd(msc_pkg::CMD_LOAD, 12'h000);
        send_cmd(msc_pkg::CMD_TICK, 12'hAAA);
        send_cmd(msc_pkg::CMD_TICK, 12'h555);
        send_cmd(msc_pkg::CMD_CLEAR, 12'h000);
        send_cmd(msc_pkg::CMD_CLEAR, 12'h000);
        send_cmd(msc_pkg::CMD_LOAD, 12'hFFF);
        send_cmd(msc_pkg::CMD_TICK, 12'h000);
        send_cmd(msc_pkg::CMD_TICK, 12'h000);
        send_cmd(CMD_UNUSED, 12'h000);
        send_cmd(msc_pkg::CMD_CLEAR, 12'h000);
        send_cmd(msc_pkg::CMD_LOAD, 12'd220);
        send_cmd(msc_pkg::CMD_TICK, 12'h000);
        send_cmd(msc_pkg::CMD_LOAD, 12'd221);
        send_cmd(msc_pkg::CMD_TICK, 12'h000);
        send_cmd(msc_pkg::CMD_TICK, 12'h000);
        send_cmd(msc_pkg::CMD_LOAD, 12'hAAA);
        send_cmd(msc_pkg::CMD_TICK, 12'h000);
        send_cmd(msc_pkg::CMD_LOAD, 12'h555);
        send_cmd(msc_pkg::CMD_TICK, 12'h000);
        send_cmd(msc_pkg::CMD_LOAD, 12'd224);

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0:       configure(32'd240, 32'd10);
                1:       configure(32'd1023, 32'd0);
                2:       configure(32'd1, 32'd255);
                3:       configure(32'hFFFF_FC00, 32'hFFFF_FF00);
                4:       configure(32'h0000_0550, 32'hABCD_EF20);
                default: configure($urandom, $urandom);
            endcase
            start  = taken_count;
            target = (ph == 0) ? 240 : 58;
            while (taken_count - start < target) run_label(target - (taken_count - start));
        end

        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (sb.errors == 0) begin
            $display("marquee_scroll_controller test passed");
        end else begin
            $display("marquee_scroll_controller test failed");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("marquee_scroll_controller test failed");
        $finish;
    end

endmodule
